### hdl/aip_pkg.sv
`timescale 1ns / 1ps

package aip_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int POS_WIDTH      = 8;
    localparam int MAX_STRING_LEN = 256;

    localparam logic [POS_WIDTH-1:0] POS_LIMIT =
        ((MAX_STRING_LEN - 1) < 255) ? POS_WIDTH'(MAX_STRING_LEN - 1) : POS_WIDTH'(255);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] LETTER_MIN = 8'd17;
    localparam logic [7:0] LETTER_ADJ = 8'd7;
    localparam logic [7:0] DEC_MAX    = 8'd9;

    typedef logic [VALUE_WIDTH-1:0] acc_t;
    typedef logic [POS_WIDTH-1:0]   pos_t;

    typedef enum logic [2:0]
    {
        PH_IDLE,
        PH_SIGN,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0]
    {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX,
        RADIX_BIN
    } radix_t;

    typedef struct packed
    {
        logic [7:0] char_code;
        logic       end_of_string;
    } char_req_t;

    typedef struct packed
    {
        logic                          parse_ok;
        logic signed [VALUE_WIDTH-1:0] number_value;
        logic [POS_WIDTH-1:0]          stop_position;
    } result_req_t;

    typedef struct packed
    {
        phase_t phase;
        logic   neg;
        radix_t radix;
        acc_t   acc;
        pos_t   pos;
    } aip_state_t;

    typedef struct packed
    {
        logic        emit;
        result_req_t res;
        aip_state_t  state;
    } aip_step_t;

endpackage

### hdl/ascii_integer_parser.sv
`timescale 1ns / 1ps

// Converts a text string, one character per request, into a signed 32-bit integer with an
// optional minus sign and a 0 (octal), 0x (hex) or 0b (binary) prefix, and returns one
// result per string: an ok flag, the value (zero on error) and the position of the character
// that stopped the parse. A character request is taken in every cycle unless the input
// stalls; it passes an input register and one decode-and-accumulate step, and its result,
// if it causes one, is written to the result register. The step carries the parse state
// from one character to the next, and the result register holds a finished result until
// it is taken; input stalls only while the result register is full and not taken.

module ascii_integer_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  aip_pkg::char_req_t   char_req,
    output logic                 result_valid,
    input  logic                 result_ready,
    output aip_pkg::result_req_t result_req
);

    logic                 in_valid_reg;
    aip_pkg::char_req_t   in_req_reg;
    aip_pkg::aip_state_t  state_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    aip_pkg::result_req_t out_req_reg;
    aip_pkg::aip_step_t   step;
    logic                 advance;

    aip_step u_step
    (
        .state (state_reg),
        .req   (in_req_reg),
        .step  (step)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign char_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result_req   = out_req_reg;

    always_comb
    begin
        if (advance && step.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (char_ready)
            begin
                in_valid_reg <= char_valid;
            end
            if (advance)
            begin
                state_reg <= step.state;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
        begin
            in_req_reg <= char_req;
        end
        if (advance && step.emit)
        begin
            out_req_reg <= step.res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_req_reg.parse_ok |-> out_req_reg.number_value == '0)
        else $error("failed parse carries a nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && step.emit |=> out_valid_reg)
        else $error("emitted result not registered");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_req_reg))
        else $error("stalled character lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pos <= aip_pkg::POS_LIMIT)
        else $error("position past its limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_req_reg.end_of_string |=> state_reg == '0)
        else $error("state not cleared at end of string");

endmodule

### hdl/aip_step.sv
`timescale 1ns / 1ps

module aip_step
(
    input  aip_pkg::aip_state_t state,
    input  aip_pkg::char_req_t  req,
    output aip_pkg::aip_step_t  step
);

    typedef struct packed
    {
        logic                decided;
        aip_pkg::result_req_t res;
        aip_pkg::aip_state_t  st;
    } feed_t;

    function automatic logic [4:0] radix_value(aip_pkg::radix_t r);
        logic [4:0] v;
        case (r)
            aip_pkg::RADIX_DEC: v = 5'd10;
            aip_pkg::RADIX_OCT: v = 5'd8;
            aip_pkg::RADIX_HEX: v = 5'd16;
            aip_pkg::RADIX_BIN: v = 5'd2;
            default:            v = 5'd10;
        endcase
        return v;
    endfunction

    function automatic aip_pkg::acc_t scale(aip_pkg::acc_t a, aip_pkg::radix_t r);
        aip_pkg::acc_t v;
        case (r)
            aip_pkg::RADIX_DEC: v = aip_pkg::acc_t'((a << 3) + (a << 1));
            aip_pkg::RADIX_OCT: v = aip_pkg::acc_t'(a << 3);
            aip_pkg::RADIX_HEX: v = aip_pkg::acc_t'(a << 4);
            aip_pkg::RADIX_BIN: v = aip_pkg::acc_t'(a << 1);
            default:            v = a;
        endcase
        return v;
    endfunction

    function automatic feed_t feed(aip_pkg::aip_state_t s, logic [7:0] c);
        feed_t      f;
        logic       sign_chk;
        logic       is_dec;
        logic       run;
        logic       bad;
        logic [7:0] d;
        f          = '0;
        f.st       = s;
        f.res.stop_position = s.pos;
        is_dec     = (c >= aip_pkg::CH_ZERO) && (c <= aip_pkg::CH_NINE);
        sign_chk   = (s.phase == aip_pkg::PH_SIGN) ||
                     ((s.phase == aip_pkg::PH_IDLE) && (c != aip_pkg::CH_SPACE) &&
                      (c != aip_pkg::CH_MINUS));
        run        = 1'b0;
        bad        = 1'b0;
        d          = c;
        if ((s.phase == aip_pkg::PH_IDLE) && (c == aip_pkg::CH_MINUS))
        begin
            f.st.neg   = 1'b1;
            f.st.phase = aip_pkg::PH_SIGN;
        end
        if (sign_chk)
        begin
            if (c == aip_pkg::CH_ZERO)
            begin
                f.st.phase = aip_pkg::PH_ZERO;
            end
            else if (!is_dec)
            begin
                f.decided = 1'b1;
            end
            else
            begin
                f.st.radix = aip_pkg::RADIX_DEC;
                f.st.phase = aip_pkg::PH_DIGITS;
                run        = 1'b1;
            end
        end
        else if (s.phase == aip_pkg::PH_ZERO)
        begin
            if (c == aip_pkg::CH_LOWER_X)
            begin
                f.st.radix = aip_pkg::RADIX_HEX;
                f.st.phase = aip_pkg::PH_DIGITS;
            end
            else if (c == aip_pkg::CH_LOWER_B)
            begin
                f.st.radix = aip_pkg::RADIX_BIN;
                f.st.phase = aip_pkg::PH_DIGITS;
            end
            else if (c <= aip_pkg::CH_SPACE)
            begin
                f.decided      = 1'b1;
                f.res.parse_ok = 1'b1;
            end
            else if (!is_dec)
            begin
                f.decided = 1'b1;
            end
            else
            begin
                f.st.radix = aip_pkg::RADIX_OCT;
                f.st.phase = aip_pkg::PH_DIGITS;
                run        = 1'b1;
            end
        end
        else if (s.phase == aip_pkg::PH_DIGITS)
        begin
            run = 1'b1;
        end

        if (run)
        begin
            if (c <= aip_pkg::CH_SPACE)
            begin
                f.decided          = 1'b1;
                f.res.parse_ok     = 1'b1;
                f.res.number_value = s.neg ? (aip_pkg::acc_t'(0) - s.acc) : s.acc;
            end
            else
            begin
                if (d >= aip_pkg::CH_LOWER_A)
                begin
                    d = d - aip_pkg::CASE_GAP;
                end
                d = d - aip_pkg::CH_ZERO;
                if (d >= aip_pkg::LETTER_MIN)
                begin
                    d = d - aip_pkg::LETTER_ADJ;
                    if (d <= aip_pkg::DEC_MAX)
                    begin
                        bad = 1'b1;
                    end
                end
                if (d >= {3'b000, radix_value(f.st.radix)})
                begin
                    bad = 1'b1;
                end
                if (bad)
                begin
                    f.decided = 1'b1;
                end
                else
                begin
                    f.st.acc = scale(s.acc, f.st.radix) + aip_pkg::acc_t'(d[3:0]);
                end
            end
        end
        return f;
    endfunction

    feed_t               first;
    feed_t               second;
    aip_pkg::aip_state_t mid;

    always_comb
    begin
        first = feed(state, req.char_code);
        mid   = first.st;
        if (state.pos < aip_pkg::POS_LIMIT)
        begin
            mid.pos = state.pos + 1'b1;
        end
        second = feed(mid, aip_pkg::CH_NUL);

        step = '0;
        if (state.phase == aip_pkg::PH_DONE)
        begin
            step.state = req.end_of_string ? aip_pkg::aip_state_t'('0) : state;
        end
        else if (first.decided)
        begin
            step.emit        = 1'b1;
            step.res         = first.res;
            step.state       = first.st;
            step.state.phase = aip_pkg::PH_DONE;
            if (req.end_of_string)
            begin
                step.state = '0;
            end
        end
        else if (req.end_of_string)
        begin
            step.emit  = second.decided;
            step.res   = second.res;
            step.state = '0;
        end
        else
        begin
            step.state = mid;
        end
    end

endmodule
